FILE: sv/hpf_pkg.sv
package hpf_pkg;

    localparam int STATUS_W = 3;
    localparam int POS_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int THR_W    = 16;
    localparam int HYS_W    = 15;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PEAK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FIT_FAIL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_END_OK      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_START_ABOVE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_END_ABOVE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd5;

    // search phase codes
    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_SEARCH = 2'd1;
    localparam logic [1:0] PH_PULSE  = 2'd2;
    localparam logic [1:0] PH_HALT   = 2'd3;

    // register indexes
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_HYSTERESIS = 1'b1;

    // vertex offset cap, in 1/256 sample
    localparam int OFF_CAP_LOG2 = 41;

    typedef struct packed {
        logic             done;
        logic             fail;
        logic [POS_W-1:0] pos;
    } fit_res_t;

endpackage

FILE: sv/hpf_ram.sv
module hpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/hpf_mul.sv
module hpf_mul #(
    parameter int A_W = 30,
    parameter int B_W = 16
) (
    input  logic                        clk,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   prod
);

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

FILE: sv/hpf_fit.sv
module hpf_fit #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 64,
    parameter int INDEX_BITS  = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]  len,
    input  logic signed [SAMPLE_BITS-1:0]    prev,
    input  logic [INDEX_BITS-1:0]            start_idx,
    output logic [$clog2(MAX_WINDOW)-1:0]    ram_raddr,
    input  logic signed [SAMPLE_BITS-1:0]    ram_rdata,
    input  logic                             ack,
    output logic                             busy,
    output hpf_pkg::fit_res_t                res
);

    localparam int LEN_W  = $clog2(MAX_WINDOW+1);
    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int HW     = $clog2(MAX_WINDOW/2+1);
    localparam int K_W    = $clog2(MAX_WINDOW+2);
    localparam int T1_W   = SAMPLE_BITS + 2*HW + 2;
    localparam int B_W    = 2*HW + 4;
    localparam int PROD_W = T1_W + B_W;
    localparam int D_W    = SAMPLE_BITS + 3*HW + 4;
    localparam int DV_W   = D_W + 3;
    localparam int NUM_W  = PROD_W + 6;
    localparam int CNT_W  = $clog2(NUM_W+1);
    localparam int QX_W   = (NUM_W > hpf_pkg::OFF_CAP_LOG2+2) ? NUM_W
                                                              : hpf_pkg::OFF_CAP_LOG2+2;
    localparam int OFF_W  = hpf_pkg::OFF_CAP_LOG2 + 1;
    localparam int TW     = INDEX_BITS + 8 + OFF_W + 2;
    localparam logic [QX_W-1:0] CAP = QX_W'(1) << hpf_pkg::OFF_CAP_LOG2;
    localparam logic signed [TW-1:0] TOP = (TW'(1) << (INDEX_BITS+8)) - TW'(1);

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_PSET = 4'd1;
    localparam logic [3:0] F_PGET = 4'd2;
    localparam logic [3:0] F_ADDR = 4'd3;
    localparam logic [3:0] F_M1   = 4'd4;
    localparam logic [3:0] F_A1   = 4'd5;
    localparam logic [3:0] F_A2   = 4'd6;
    localparam logic [3:0] F_CHK  = 4'd7;
    localparam logic [3:0] F_NUM  = 4'd8;
    localparam logic [3:0] F_DIV  = 4'd9;
    localparam logic [3:0] F_POS  = 4'd10;
    localparam logic [3:0] F_FIN  = 4'd11;

    logic [3:0]                    state_reg;
    logic [HW-1:0]                 h_reg;
    logic                          pad_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic [INDEX_BITS-1:0]         sidx_reg;
    logic [K_W-1:0]                k_reg;
    logic signed [B_W-1:0]         i_reg;
    logic signed [B_W-1:0]         c2_reg;
    logic signed [B_W-1:0]         coef_reg;
    logic signed [T1_W-1:0]        t1_reg;
    logic signed [D_W-1:0]         d_reg;
    logic                          neg_reg;
    logic [DV_W-1:0]               dv_reg;
    logic [NUM_W-1:0]              num_reg;
    logic [DV_W-1:0]               rem_reg;
    logic [NUM_W-1:0]              q_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          fail_reg;
    logic [hpf_pkg::POS_W-1:0]     pos_reg;

    logic signed [T1_W-1:0]        mul_a;
    logic signed [B_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [SAMPLE_BITS-1:0] y_sel;
    logic [HW-1:0]                 h_in;
    logic signed [B_W-1:0]         p_s;
    logic signed [B_W-1:0]         h_b;
    logic signed [T1_W-1:0]        t1_mag;
    logic signed [D_W-1:0]         d_mag;
    logic [DV_W:0]                 trial;
    logic [QX_W-1:0]               q_x;
    logic [OFF_W-1:0]              off_mag;
    logic [INDEX_BITS-1:0]         center;
    logic signed [TW-1:0]          base;
    logic signed [TW-1:0]          total;
    logic signed [TW-1:0]          clamped;

    hpf_mul #(
        .A_W (T1_W),
        .B_W (B_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign h_in      = HW'(len >> 1);
    assign ram_raddr = AW'(k_reg - K_W'(pad_reg));
    assign y_sel     = (pad_reg && (k_reg == '0)) ? prev_reg : ram_rdata;
    assign p_s       = $signed(prod[B_W-1:0]);
    assign h_b       = $signed(B_W'(h_reg));
    assign t1_mag    = (t1_reg < 0) ? -t1_reg : t1_reg;
    assign d_mag     = (d_reg < 0) ? -d_reg : d_reg;
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign q_x       = QX_W'(q_reg);
    assign off_mag   = (q_x >= CAP) ? OFF_W'(CAP) : OFF_W'(q_x);
    assign center    = sidx_reg - INDEX_BITS'(pad_reg) + INDEX_BITS'(h_reg);
    assign base      = $signed(TW'({center, 8'b0}));
    assign total     = neg_reg ? base - $signed(TW'(off_mag)) : base + $signed(TW'(off_mag));
    assign clamped   = (total < 0) ? '0 : ((total > TOP) ? TOP : total);

    // one multiplier serves p, both sums and the numerator
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            F_PSET:
            begin
                mul_a = $signed(T1_W'(h_reg));
                mul_b = h_b + B_W'(1);
            end
            F_M1:
            begin
                mul_a = T1_W'(y_sel);
                mul_b = i_reg;
            end
            F_A1:
            begin
                mul_a = T1_W'(y_sel);
                mul_b = c2_reg;
            end
            F_CHK:
            begin
                mul_a = t1_mag;
                mul_b = coef_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= F_PSET;
                    end
                end
                F_PSET: state_reg <= F_PGET;
                F_PGET: state_reg <= F_ADDR;
                F_ADDR: state_reg <= F_M1;
                F_M1:   state_reg <= F_A1;
                F_A1:   state_reg <= F_A2;
                F_A2:   state_reg <= (k_reg == K_W'({h_reg, 1'b0})) ? F_CHK : F_ADDR;
                F_CHK:  state_reg <= (d_reg == '0) ? F_FIN : F_NUM;
                F_NUM:  state_reg <= F_DIV;
                F_DIV:  state_reg <= (cnt_reg == '0) ? F_POS : F_DIV;
                F_POS:  state_reg <= F_FIN;
                F_FIN:
                begin
                    if (ack)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                h_reg    <= h_in;
                pad_reg  <= ~len[0];
                prev_reg <= prev;
                sidx_reg <= start_idx;
                fail_reg <= 1'b0;
                pos_reg  <= '0;
            end
            F_PGET:
            begin
                // offsets run from -h; 3i^2-p at i=-h is 2p-3h
                i_reg    <= -h_b;
                c2_reg   <= (p_s <<< 1) - h_b - (h_b <<< 1);
                coef_reg <= (p_s <<< 2) - B_W'(3);
                k_reg    <= '0;
                t1_reg   <= '0;
                d_reg    <= '0;
            end
            F_A1:
            begin
                t1_reg <= t1_reg + $signed(prod[T1_W-1:0]);
            end
            F_A2:
            begin
                d_reg  <= d_reg + $signed(prod[D_W-1:0]);
                k_reg  <= k_reg + K_W'(1);
                i_reg  <= i_reg + B_W'(1);
                c2_reg <= c2_reg + (i_reg <<< 2) + (i_reg <<< 1) + B_W'(3);
            end
            F_CHK:
            begin
                fail_reg <= (d_reg == '0);
                neg_reg  <= (t1_reg < 0) == (d_reg < 0);
                dv_reg   <= DV_W'(d_mag) + (DV_W'(d_mag) << 2);
            end
            F_NUM:
            begin
                num_reg <= {prod[PROD_W-2:0], 7'b0};
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= CNT_W'(NUM_W-1);
            end
            F_DIV:
            begin
                // restoring division, one quotient bit per cycle
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (trial >= {1'b0, dv_reg})
                begin
                    rem_reg <= DV_W'(trial - {1'b0, dv_reg});
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[DV_W-1:0];
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
            end
            F_POS:
            begin
                pos_reg <= clamped[hpf_pkg::POS_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign busy     = (state_reg != F_IDLE);
    assign res.done = (state_reg == F_FIN);
    assign res.fail = fail_reg;
    assign res.pos  = pos_reg;

endmodule

FILE: sv/hysteresis_peak_finder.sv
// Hysteresis peak finder. Samples arrive on the s_axis stream (tlast marks
// the last sample of a series); results leave on m_axis with the status in
// tuser. A sample that does not close a pulse is taken without a fit. A
// closing sample starts a least-squares parabola fit over the window of
// n = 2h+1 samples, run on one shared multiplier and a bit-serial divider
// that gives one quotient bit per cycle, 52 numerator bits with the default
// widths; the division is skipped when the fit denominator is zero. During
// the fit, and while a finished result waits for m_axis_tready,
// s_axis_tready is low. Thresholds are written over the APB port:
// threshold at 0x0, hysteresis at 0x4.
module hysteresis_peak_finder #(
    parameter int MAX_WINDOW  = 64,
    parameter int INDEX_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tlast,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // peak_position [31:0], peak_number [47:32]
    output logic [47:0]                          m_axis_tdata,
    // status [2:0]
    output logic [2:0]                           m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int LEN_W = $clog2(MAX_WINDOW+1);
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CMP_W = ((SAMPLE_BITS > hpf_pkg::THR_W) ? SAMPLE_BITS
                                                           : hpf_pkg::THR_W) + 2;

    logic signed [hpf_pkg::THR_W-1:0]  thr_reg;
    logic [hpf_pkg::HYS_W-1:0]         hys_reg;
    logic [1:0]                        phase_reg;
    logic [LEN_W-1:0]                  len_reg;
    logic [INDEX_BITS-1:0]             sidx_reg;
    logic [INDEX_BITS-1:0]             idx_reg;
    logic signed [SAMPLE_BITS-1:0]     prev_reg;
    logic [hpf_pkg::COUNT_W-1:0]       peaks_reg;
    logic signed [SAMPLE_BITS-1:0]     yclose_reg;
    logic                              close_above_reg;
    logic                              out_valid_reg;
    logic [hpf_pkg::STATUS_W-1:0]      out_status_reg;
    logic [hpf_pkg::POS_W-1:0]         out_pos_reg;
    logic [hpf_pkg::COUNT_W-1:0]       out_num_reg;

    logic signed [SAMPLE_BITS-1:0]     sample;
    logic signed [CMP_W-1:0]           y_c;
    logic signed [CMP_W-1:0]           thr_c;
    logic signed [CMP_W-1:0]           eps_c;
    logic                              above;
    logic                              opens;
    logic                              closes;
    logic                              accept;
    logic                              out_free;
    logic                              out_load;
    logic                              cfg_wr;
    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [AW-1:0]                     ram_raddr;
    logic signed [SAMPLE_BITS-1:0]     ram_rdata;
    logic                              fit_start;
    logic                              fit_busy;
    hpf_pkg::fit_res_t                 fit_res;

    assign sample = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign y_c    = CMP_W'(sample);
    assign thr_c  = CMP_W'(thr_reg);
    assign eps_c  = $signed(CMP_W'(hys_reg));
    assign above  = (y_c >= thr_c);
    assign opens  = (y_c >= thr_c + eps_c);
    assign closes = (y_c <= thr_c - eps_c);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !fit_busy && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // a result is loaded by a finished fit, the last sample, a start above
    // threshold or a window overflow
    assign out_load = (fit_res.done && out_free)
                      || (accept && (s_axis_tlast
                          || ((phase_reg == hpf_pkg::PH_WAIT) && above)
                          || ((phase_reg == hpf_pkg::PH_PULSE)
                              && (len_reg >= LEN_W'(MAX_WINDOW)))));

    assign ram_we    = accept && !s_axis_tlast
                       && (((phase_reg == hpf_pkg::PH_SEARCH) && opens)
                           || ((phase_reg == hpf_pkg::PH_PULSE)
                               && (len_reg < LEN_W'(MAX_WINDOW))));
    assign ram_waddr = (phase_reg == hpf_pkg::PH_PULSE) ? len_reg[AW-1:0] : '0;
    assign fit_start = accept && !s_axis_tlast && (phase_reg == hpf_pkg::PH_PULSE)
                       && (len_reg < LEN_W'(MAX_WINDOW)) && closes;

    hpf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hpf_fit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW),
        .INDEX_BITS  (INDEX_BITS)
    ) u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fit_start),
        .len       (len_reg + LEN_W'(1)),
        .prev      (prev_reg),
        .start_idx (sidx_reg),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ack       (out_free),
        .busy      (fit_busy),
        .res       (fit_res)
    );

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            hpf_pkg::REG_THRESHOLD:  prdata = 32'({thr_reg});
            hpf_pkg::REG_HYSTERESIS: prdata = 32'(hys_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'sd19661;
            hys_reg <= 15'd328;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                hpf_pkg::REG_THRESHOLD:  thr_reg <= $signed(pwdata[hpf_pkg::THR_W-1:0]);
                hpf_pkg::REG_HYSTERESIS: hys_reg <= pwdata[hpf_pkg::HYS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // search control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hpf_pkg::PH_WAIT;
            len_reg       <= '0;
            sidx_reg      <= '0;
            idx_reg       <= '0;
            prev_reg      <= '0;
            peaks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fit_res.done && out_free)
            begin
                prev_reg <= yclose_reg;
                if (fit_res.fail)
                begin
                    phase_reg <= hpf_pkg::PH_HALT;
                end
                else
                begin
                    peaks_reg <= peaks_reg + hpf_pkg::COUNT_W'(1);
                    phase_reg <= close_above_reg ? hpf_pkg::PH_HALT : hpf_pkg::PH_SEARCH;
                end
            end

            if (accept)
            begin
                idx_reg <= s_axis_tlast ? '0 : idx_reg + INDEX_BITS'(1);
                if (s_axis_tlast)
                begin
                    phase_reg     <= hpf_pkg::PH_WAIT;
                    len_reg       <= '0;
                    sidx_reg      <= '0;
                    prev_reg      <= '0;
                    peaks_reg     <= '0;
                end
                else
                begin
                    case (phase_reg)
                        hpf_pkg::PH_WAIT:
                        begin
                            prev_reg <= sample;
                            if (above)
                            begin
                                phase_reg     <= hpf_pkg::PH_HALT;
                            end
                            else
                            begin
                                phase_reg <= hpf_pkg::PH_SEARCH;
                            end
                        end
                        hpf_pkg::PH_SEARCH:
                        begin
                            if (opens)
                            begin
                                len_reg   <= LEN_W'(1);
                                sidx_reg  <= idx_reg;
                                phase_reg <= hpf_pkg::PH_PULSE;
                            end
                            else
                            begin
                                prev_reg <= sample;
                            end
                        end
                        hpf_pkg::PH_PULSE:
                        begin
                            if (len_reg >= LEN_W'(MAX_WINDOW))
                            begin
                                phase_reg     <= hpf_pkg::PH_HALT;
                                prev_reg      <= sample;
                            end
                            else if (!closes)
                            begin
                                len_reg <= len_reg + LEN_W'(1);
                            end
                        end
                        default:
                        begin
                            prev_reg <= sample;
                        end
                    endcase
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fit_start)
        begin
            yclose_reg      <= sample;
            close_above_reg <= above;
        end
        if (fit_res.done && out_free)
        begin
            out_status_reg <= fit_res.fail ? hpf_pkg::ST_FIT_FAIL : hpf_pkg::ST_PEAK;
            out_pos_reg    <= fit_res.fail ? '0 : fit_res.pos;
            out_num_reg    <= peaks_reg;
        end
        if (accept)
        begin
            out_pos_reg <= '0;
            if (s_axis_tlast)
            begin
                out_status_reg <= above ? hpf_pkg::ST_END_ABOVE : hpf_pkg::ST_END_OK;
                out_num_reg    <= peaks_reg;
            end
            else if (phase_reg == hpf_pkg::PH_WAIT)
            begin
                out_status_reg <= hpf_pkg::ST_START_ABOVE;
                out_num_reg    <= '0;
            end
            else
            begin
                out_status_reg <= hpf_pkg::ST_OVERFLOW;
                out_num_reg    <= peaks_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_num_reg, out_pos_reg};

`ifndef SYNTH
    a_no_accept_during_fit: assert property (@(posedge clk) disable iff (!rst_n)
        fit_busy |-> !s_axis_tready)
        else $error("sample accepted while fit runs");

    a_fit_from_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        fit_start |-> (phase_reg == hpf_pkg::PH_PULSE) && (len_reg != '0))
        else $error("fit started outside a pulse");

    a_pulse_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hpf_pkg::PH_PULSE) |-> (len_reg != '0)
            && (len_reg <= LEN_W'(MAX_WINDOW)))
        else $error("pulse length out of range");

    a_fit_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (fit_res.done && out_free) |=> m_axis_tvalid)
        else $error("fit result not presented");
`endif

endmodule

FILE: sim/hysteresis_peak_finder_tb.sv
`timescale 1ns / 1ps

module hysteresis_peak_finder_tb;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } sample_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] position;
        logic [15:0] number;
    } peak_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    hysteresis_peak_finder uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    sample_t     pending_samples[$];
    peak_res_t   expected_peaks[$];
    int          errors = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          in_fire = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;

    // predictor state
    logic signed [15:0] p_thr;
    logic [14:0]        p_hys;
    logic signed [15:0] p_win[64];
    int                 p_len;
    logic [23:0]        p_start;
    logic [23:0]        p_idx;
    logic signed [15:0] p_prev;
    logic [1:0]         p_phase;
    logic [15:0]        p_count;

    task automatic clear_series();
        for (int k = 0; k < 64; k++) p_win[k] = '0;
        p_len = 0;
        p_start = '0;
        p_idx = '0;
        p_prev = '0;
        p_phase = hpf_pkg::PH_WAIT;
        p_count = '0;
    endtask

    task automatic expect_result(input peak_res_t r);
        expected_peaks.insert(expected_peaks.size(), r);
    endtask

    // vertex fit; returns 1 if the denominator vanishes
    function automatic bit fit_vertex(output logic [31:0] pos);
        int pad, n;
        longint h, p, t1, den, y, i, off, total, center;
        logic [127:0] num, q;
        logic [63:0] dv;
        pad = (p_len & 1) ? 0 : 1;
        n = p_len + pad;
        h = (n - 1) / 2;
        p = h * (h + 1);
        t1 = 0;
        den = 0;
        pos = '0;
        for (int k = 0; k < n; k++)
        begin
            i = k - h;
            if (pad && k == 0) y = p_prev;
            else y = p_win[k - pad];
            t1 += y * i;
            den += y * (3 * i * i - p);
        end
        if (den == 0) return 1'b1;
        num = 128'(t1 < 0 ? -t1 : t1) * 128'((4 * p - 3) * 128);
        dv = 64'(5 * (den < 0 ? -den : den));
        q = num / 128'(dv);
        if (q > (128'd1 << hpf_pkg::OFF_CAP_LOG2)) q = 128'd1 << hpf_pkg::OFF_CAP_LOG2;
        off = ((t1 < 0) == (den < 0)) ? -longint'(q) : longint'(q);
        center = longint'(24'(p_start - 24'(pad) + 24'(h)));
        total = center * 256 + off;
        if (total < 0) total = 0;
        if (total > 64'hffffffff) total = 64'hffffffff;
        pos = total[31:0];
        return 1'b0;
    endfunction

    task automatic predict_sample(input sample_t s);
        logic signed [16:0] y, thr, eps;
        peak_res_t r;
        logic [31:0] pos;
        y = 17'(signed'(s.sample));
        thr = 17'(p_thr);
        eps = 17'(signed'({1'b0, p_hys}));
        if (s.last)
        begin
            r.status = (y >= thr) ? hpf_pkg::ST_END_ABOVE : hpf_pkg::ST_END_OK;
            r.position = '0;
            r.number = p_count;
            expect_result(r);
            clear_series();
            return;
        end
        case (p_phase)
            hpf_pkg::PH_WAIT:
            begin
                if (y >= thr)
                begin
                    r.status = hpf_pkg::ST_START_ABOVE;
                    r.position = '0;
                    r.number = '0;
                    expect_result(r);
                    p_phase = hpf_pkg::PH_HALT;
                end
                else
                begin
                    p_phase = hpf_pkg::PH_SEARCH;
                end
            end
            hpf_pkg::PH_SEARCH:
            begin
                if (y >= thr + eps)
                begin
                    p_win[0] = s.sample;
                    p_len = 1;
                    p_start = p_idx;
                    p_phase = hpf_pkg::PH_PULSE;
                end
            end
            hpf_pkg::PH_PULSE:
            begin
                if (p_len >= 64)
                begin
                    r.status = hpf_pkg::ST_OVERFLOW;
                    r.position = '0;
                    r.number = p_count;
                    expect_result(r);
                    p_phase = hpf_pkg::PH_HALT;
                end
                else
                begin
                    p_win[p_len] = s.sample;
                    p_len++;
                    if (y <= thr - eps)
                    begin
                        r.number = p_count;
                        if (fit_vertex(pos))
                        begin
                            r.status = hpf_pkg::ST_FIT_FAIL;
                            r.position = '0;
                            p_phase = hpf_pkg::PH_HALT;
                        end
                        else
                        begin
                            r.status = hpf_pkg::ST_PEAK;
                            r.position = pos;
                            p_count++;
                            p_phase = (y >= thr) ? hpf_pkg::PH_HALT : hpf_pkg::PH_SEARCH;
                        end
                        expect_result(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (p_phase != hpf_pkg::PH_PULSE) p_prev = s.sample;
        p_idx++;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_fire)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    if (!calm && $urandom_range(0, 9) == 0)
                    begin
                        src_gap = $urandom_range(0, 18);
                        s_axis_tvalid <= 1'b0;
                    end
                    else
                    begin
                        s_axis_tdata <= pending_samples[0].sample;
                        s_axis_tlast <= pending_samples[0].last;
                        predict_sample(pending_samples.pop_front());
                        s_axis_tvalid <= 1'b1;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        peak_res_t e;
        cycle_count++;
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_peaks.size() == 0)
            begin
                $error("unexpected result status %0d", m_axis_tuser);
                errors++;
            end
            else
            begin
                e = expected_peaks.pop_front();
                if (m_axis_tuser !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== e.position)
                begin
                    $error("peak_position expected %h actual %h",
                           e.position, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== e.number)
                begin
                    $error("peak_number expected %0d actual %0d",
                           e.number, m_axis_tdata[47:32]);
                    errors++;
                end
            end
        end
        if (cycle_count > 2000000)
        begin
            $display("hysteresis_peak_finder regression: fail");
            $finish;
        end
    end

    task automatic reg_write(input logic addr_sel, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {addr_sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr_sel == hpf_pkg::REG_THRESHOLD) p_thr = value[15:0];
        else p_hys = value[14:0];
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_peaks.size() > 0
               || s_axis_tvalid) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic add(input logic [15:0] v, input logic l);
        sample_t s;
        s.sample = v;
        s.last = l;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    // one series: a usually quiet first sample, then pulses of random shape, then last
    task automatic add_series(input int pulses, input int max_len);
        int thr, hys, top, len;
        thr = p_thr;
        hys = p_hys;
        add(16'($urandom_range(0, 3) == 0 ? $urandom
                                          : thr - hys - 1 - $urandom_range(0, 500)),
            1'b0);
        for (int k = 0; k < pulses; k++)
        begin
            repeat ($urandom_range(0, 3)) add(16'(thr - hys - 1 - $urandom_range(0, 800)), 1'b0);
            len = $urandom_range(1, max_len);
            top = thr + hys + $urandom_range(0, 3000);
            if (top > 32767) top = 32767;
            add(16'(top - $urandom_range(0, 200)), 1'b0);
            for (int j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 15) == 0) add(16'($urandom), 1'b0);
                else add(16'(thr - hys + 1 + $urandom_range(0, top - thr + hys)), 1'b0);
            end
            add(16'(thr - hys - $urandom_range(0, 2000)), 1'b0);
        end
        add(16'($urandom), 1'b1);
    endtask

    initial
    begin
        p_thr = 16'sd19661;
        p_hys = 15'd328;
        clear_series();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: defaults, start above, extremes, overflow
        add(16'h0000, 1'b0); add(16'h7fff, 1'b0); add(16'h7000, 1'b0);
        add(16'h8000, 1'b0); add(16'h7fff, 1'b1);
        add(16'h7fff, 1'b0); add(16'h0000, 1'b0); add(16'h8000, 1'b1);
        add(16'h0000, 1'b0); add(16'h0000, 1'b1);
        drain();
        reg_write(hpf_pkg::REG_HYSTERESIS, 32'hffff_0000);
        reg_write(hpf_pkg::REG_THRESHOLD, 32'h0000_0000);
        // zero hysteresis: closing sample equal to threshold halts
        add(16'hff00, 1'b0); add(16'h0100, 1'b0); add(16'h0000, 1'b0);
        add(16'h0100, 1'b0); add(16'h0000, 1'b1);
        // zero data in window; the padding sample ffff keeps the denominator nonzero
        add(16'hffff, 1'b0); add(16'h0000, 1'b0); add(16'h0000, 1'b0);
        add(16'h0000, 1'b1);
        drain();
        reg_write(hpf_pkg::REG_THRESHOLD, 32'h0000_8000);
        reg_write(hpf_pkg::REG_HYSTERESIS, 32'h0000_7fff);
        add(16'h8000, 1'b0); add(16'h7fff, 1'b0); add(16'h8000, 1'b1);
        drain();
        reg_write(hpf_pkg::REG_THRESHOLD, 32'h0000_0100);
        reg_write(hpf_pkg::REG_HYSTERESIS, 32'h0000_0010);
        add(16'h0000, 1'b0); add(16'h0200, 1'b0);
        repeat (64) add(16'h0300, 1'b0);
        add(16'h0000, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    reg_write(hpf_pkg::REG_THRESHOLD, 32'd19661);
                    reg_write(hpf_pkg::REG_HYSTERESIS, 32'd328);
                end
                1:
                begin
                    reg_write(hpf_pkg::REG_THRESHOLD, 32'h0000_7fff);
                    reg_write(hpf_pkg::REG_HYSTERESIS, 32'd0);
                end
                2:
                begin
                    reg_write(hpf_pkg::REG_THRESHOLD, $urandom);
                    reg_write(hpf_pkg::REG_HYSTERESIS, $urandom);
                end
                3:
                begin
                    reg_write(hpf_pkg::REG_THRESHOLD, 32'hffff_8000);
                    reg_write(hpf_pkg::REG_HYSTERESIS, 32'd50);
                end
                4:
                begin
                    reg_write(hpf_pkg::REG_THRESHOLD, 32'd1000);
                    reg_write(hpf_pkg::REG_HYSTERESIS, 32'h7fff);
                end
                default:
                begin
                    reg_write(hpf_pkg::REG_THRESHOLD, 32'd5000);
                    reg_write(hpf_pkg::REG_HYSTERESIS, 32'd200);
                end
            endcase
            if (ph == 5) calm = 1'b1;
            for (int s = 0; s < 3; s++)
                add_series($urandom_range(1, 4), (s == 0) ? 70 : 8);
            drain();
        end

        if (errors == 0)
            $display("hysteresis_peak_finder regression: pass");
        else
            $display("hysteresis_peak_finder regression: fail");
        $finish;
    end
endmodule

FILE: hysteresis_peak_finder.f
sv/hpf_pkg.sv
sv/hpf_ram.sv
sv/hpf_mul.sv
sv/hpf_fit.sv
sv/hysteresis_peak_finder.sv
sim/hysteresis_peak_finder_tb.sv
